// ===== hw/rtl/psec_pkg.sv =====
// shared types and constants for the ping synced echo capture block
`default_nettype none

package psec_pkg;

  localparam int NUM_BINS   = 128;
  localparam int AVG_DEPTH  = 10;
  localparam int SAMPLE_W   = 10;
  localparam int IDX_W      = 7;
  localparam int LEN_W      = 8;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd1020;

  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int CNT_W      = $clog2(NUM_BINS + 1);
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int BANK_DEPTH = 2 ** (BIN_W + 1);
  localparam int HIST_DEPTH = NUM_BINS * AVG_DEPTH;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int SLOT_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int K_W        = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W      = $clog2(((2 ** SAMPLE_W) - 1) * AVG_DEPTH + 1);

  // floor(sum / AVG_DEPTH) as a reciprocal multiply, exact over the sum range
  localparam int DIV_SHIFT  = 20;
  localparam int RECIP_W    = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** DIV_SHIFT + AVG_DEPTH - 1) / AVG_DEPTH);
  localparam int PROD_W     = SUM_W + RECIP_W;

  // apb
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam logic [PADDR_W-3:0] REG_PEAK_THRESHOLD = '0;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample;
    logic                sample_due;
    logic [IDX_W-1:0]    read_index;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] read_data;
    logic                peak_seen;
    logic [LEN_W-1:0]    completed_length;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PEAK,
    ST_HWR,
    ST_SUM,
    ST_DIV,
    ST_AVG,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/ping_synced_echo_capture.sv =====
// Ping synchronized sonar echo capture: bank swap on ping peaks, per-bin ping averaging.
// After reset the block clears its bin history memory, one entry per cycle, and takes no
// item until all NUM_BINS*AVG_DEPTH entries are clear; register writes are taken
// meanwhile. Items are handled one at a time by a small sequencer. A read command passes
// through a bank read state, a non-averaged sample goes straight to the result, and a
// ping peak makes a second bin write (it shares the single bank write port). A due sample
// has its history entry written, then the AVG_DEPTH entries of that bin are summed one
// per cycle through the history memory read port and a single adder, the sum is divided
// by a reciprocal multiply and the average is written to the bank. The result register
// is loaded at the end of the last busy cycle, just as the sequencer is ready again.
// A finished result sits in that output register; the next item is taken while it
// waits, and the sequencer holds only if a second result is ready before the first has
// been transferred.
`default_nettype none

module ping_synced_echo_capture (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire psec_pkg::in_item_t             in_data_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      psec_pkg::out_item_t            out_data_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [psec_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [psec_pkg::PDATA_W-1:0]   pwdata,
  output      logic [psec_pkg::PDATA_W-1:0]   prdata,
  output      logic                           pready
);
  import psec_pkg::*;

  // control state
  state_e              state_q, state_d;
  logic                sel_q;
  logic [CNT_W-1:0]    fill_q;
  logic [CNT_W-1:0]    completed_q;
  logic [SAMPLE_W-1:0] prev_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [SAMPLE_W-1:0] thr_q;
  logic [HA_W-1:0]     clr_q;
  logic [K_W-1:0]      k_q;
  logic                out_valid_q;

  // payload
  in_item_t            item_q;
  logic [HA_W-1:0]     hbase_q;
  logic [SUM_W-1:0]    sum_q;
  logic [PROD_W-1:0]   prod_q;
  logic                res_ok_q;
  logic [SAMPLE_W-1:0] res_data_q;
  logic                res_peak_q;
  out_item_t           out_q;

  // memories
  logic [SAMPLE_W-1:0] bank_mem [BANK_DEPTH];
  logic [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  logic [SAMPLE_W-1:0] bank_rdata_q;
  logic [SAMPLE_W-1:0] hist_rdata_q;

  logic                bank_we;
  logic [BIN_W:0]      bank_waddr;
  logic [SAMPLE_W-1:0] bank_wdata;
  logic [BIN_W:0]      bank_raddr;
  logic                hist_we;
  logic [HA_W-1:0]     hist_waddr;
  logic [SAMPLE_W-1:0] hist_wdata;
  logic [HA_W-1:0]     hist_raddr;
  logic                load_out;

  logic                accept;
  logic                cfg_wr;
  logic                peak_hit;
  logic                due_hit;
  logic                rd_ok;
  logic [CMP_W-1:0]    idx_ext;
  logic [SAMPLE_W-1:0] avg;
  logic [SLOT_W-1:0]   slot_next;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[PADDR_W-1:2] == REG_PEAK_THRESHOLD) ? PDATA_W'(thr_q) : '0;

  assign peak_hit = (prev_q > thr_q) && (prev_q > in_data_i.sample);
  assign due_hit  = in_data_i.sample_due && (fill_q < CNT_W'(NUM_BINS));
  assign idx_ext  = CMP_W'(in_data_i.read_index);
  assign rd_ok    = (idx_ext < CMP_W'(completed_q)) && (idx_ext < CMP_W'(NUM_BINS));
  assign avg      = prod_q[DIV_SHIFT +: SAMPLE_W];
  assign slot_next = (slot_q == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    bank_we    = 1'b0;
    bank_waddr = '0;
    bank_wdata = '0;
    bank_raddr = '0;
    hist_we    = 1'b0;
    hist_waddr = '0;
    hist_wdata = '0;
    hist_raddr = '0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_q;
        if (clr_q == HA_W'(HIST_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.cmd == CMD_READ) begin
            bank_raddr = {~sel_q, idx_ext[BIN_W-1:0]};
            state_d    = ST_READ;
          end else if (peak_hit) begin
            // bin 0 of the new bank takes the previous sample
            bank_we    = 1'b1;
            bank_waddr = {~sel_q, BIN_W'(0)};
            bank_wdata = prev_q;
            state_d    = ST_PEAK;
          end else if (due_hit) begin
            state_d = ST_HWR;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_READ: begin
        state_d = ST_RESULT;
      end
      ST_PEAK: begin
        bank_we    = 1'b1;
        bank_waddr = {sel_q, BIN_W'(1)};
        bank_wdata = item_q.sample;
        state_d    = ST_RESULT;
      end
      ST_HWR: begin
        hist_we    = 1'b1;
        hist_waddr = hbase_q + HA_W'(slot_q);
        hist_wdata = item_q.sample;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        if (k_q < K_W'(AVG_DEPTH)) begin
          hist_raddr = hbase_q + HA_W'(k_q);
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        state_d = ST_AVG;
      end
      ST_AVG: begin
        bank_we    = 1'b1;
        bank_waddr = {sel_q, fill_q[BIN_W-1:0]};
        bank_wdata = avg;
        state_d    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      fill_q      <= '0;
      completed_q <= '0;
      prev_q      <= '0;
      slot_q      <= '0;
      thr_q       <= THRESHOLD_RESET;
      clr_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[PADDR_W-1:2] == REG_PEAK_THRESHOLD)) begin
        thr_q <= pwdata[SAMPLE_W-1:0];
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept && (in_data_i.cmd == CMD_SAMPLE)) begin
        prev_q <= in_data_i.sample;
        if (peak_hit) begin
          completed_q <= fill_q;
          sel_q       <= ~sel_q;
          fill_q      <= CNT_W'(2);
          slot_q      <= slot_next;
        end
      end
      if (state_q == ST_HWR) begin
        k_q <= '0;
      end else if (state_q == ST_SUM) begin
        k_q <= k_q + 1'b1;
      end
      if (state_q == ST_AVG) begin
        fill_q <= fill_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_data_i;
      res_ok_q   <= rd_ok;
      res_data_q <= '0;
      res_peak_q <= (in_data_i.cmd == CMD_SAMPLE) && peak_hit;
      hbase_q    <= HA_W'(fill_q[BIN_W-1:0]) * HA_W'(AVG_DEPTH);
    end
    if (state_q == ST_READ) begin
      res_data_q <= res_ok_q ? bank_rdata_q : '0;
    end
    if (state_q == ST_HWR) begin
      sum_q <= '0;
    end else if ((state_q == ST_SUM) && (k_q != '0)) begin
      // read data is registered, so it arrives in the cycle after its address
      sum_q <= sum_q + SUM_W'(hist_rdata_q);
    end
    if (state_q == ST_DIV) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
    end
    if (load_out) begin
      out_q.read_data        <= res_data_q;
      out_q.peak_seen        <= res_peak_q;
      out_q.completed_length <= LEN_W'(completed_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (bank_we) begin
      bank_mem[bank_waddr] <= bank_wdata;
    end
    bank_rdata_q <= bank_mem[bank_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rdata_q <= hist_mem[hist_raddr];
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= CNT_W'(NUM_BINS)) && (completed_q <= CNT_W'(NUM_BINS)))
    else $error("bin count beyond bank size");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < SLOT_W'(AVG_DEPTH))
    else $error("history slot out of range");

  a_peak_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.cmd == CMD_SAMPLE) && peak_hit)
    |=> (fill_q == CNT_W'(2)) && (sel_q != $past(sel_q)) && res_peak_q)
    else $error("peak did not swap banks");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("transfer taken during history clear");

  a_sum_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (k_q <= K_W'(AVG_DEPTH)))
    else $error("sum counter overran");

endmodule

`default_nettype wire
